// ===== sv/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, register map and constants of the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

   localparam int COUNT_WIDTH_DEF = 12;   // default tick counter width
   localparam int THR_W           = 12;   // widest threshold register
   localparam int PADDR_W         = 5;    // five registers at 4-byte spacing
   localparam int PDATA_W         = 32;
   localparam int PAUSE_TICKS     = 5;    // closing pause, in ticks

   localparam logic [7:0]  SETTLE_RST         = 8'd10;
   localparam logic [7:0]  STABLE_PRESS_RST   = 8'd10;
   localparam logic [11:0] LONG_PRESS_RST     = 12'd2500;
   localparam logic [7:0]  RELEASE_STABLE_RST = 8'd30;
   localparam logic [11:0] DOUBLE_GAP_RST     = 12'd1000;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SETTLE,
      PH_DEBOUNCE,
      PH_HOLD,
      PH_RELEASE,
      PH_GAP,
      PH_SECOND,
      PH_FINAL
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_POWER_UP   = 3'd1,
      EV_SINGLE     = 3'd2,
      EV_DOUBLE     = 3'd3,
      EV_POWER_DOWN = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      REG_SETTLE         = 3'd0,
      REG_STABLE_PRESS   = 3'd1,
      REG_LONG_PRESS     = 3'd2,
      REG_RELEASE_STABLE = 3'd3,
      REG_DOUBLE_GAP     = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [7:0]  settle_ticks;
      logic [7:0]  stable_press_ticks;
      logic [11:0] long_press_ticks;
      logic [7:0]  release_stable_ticks;
      logic [11:0] double_gap_ticks;
   } cfg_type;

   typedef struct packed {
      event_type event_code;
      logic      supply_on;
   } result_type;

endpackage

// ===== sv/bpc_if.sv =====
// ----------------------------------------------------------------------------
// bpc_if
// Valid/ready channels for the tick items and the classification results.
// ----------------------------------------------------------------------------
interface bpc_req_if;
   logic valid;
   logic ready;
   logic button_pressed;

   modport source (output valid, output button_pressed, input ready);
   modport sink   (input valid, input button_pressed, output ready);
endinterface

interface bpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_code;
   logic       main_power_enable;
   logic       mcu_power_enable;

   modport source (output valid, output event_code, output main_power_enable,
                   output mcu_power_enable, input ready);
   modport sink   (input valid, input event_code, input main_power_enable,
                   input mcu_power_enable, output ready);
endinterface

// ===== sv/bpc_csr.sv =====
// ----------------------------------------------------------------------------
// bpc_csr
// APB register file holding the five timing thresholds.
// ----------------------------------------------------------------------------
module bpc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bpc_pkg::PADDR_W-1:0]    paddr,
   input  logic [bpc_pkg::PDATA_W-1:0]    pwdata,
   output logic [bpc_pkg::PDATA_W-1:0]    prdata,
   output logic                           pready,
   output bpc_pkg::cfg_type               cfg
);
   import bpc_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index    = reg_index_type'(paddr[PADDR_W-1:2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_SETTLE:         cfg_in.settle_ticks         = pwdata[7:0];
            REG_STABLE_PRESS:   cfg_in.stable_press_ticks   = pwdata[7:0];
            REG_LONG_PRESS:     cfg_in.long_press_ticks     = pwdata[11:0];
            REG_RELEASE_STABLE: cfg_in.release_stable_ticks = pwdata[7:0];
            REG_DOUBLE_GAP:     cfg_in.double_gap_ticks     = pwdata[11:0];
            default:            cfg_in = cfg_ff;   // drop writes past the map
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_SETTLE:         prdata = PDATA_W'(cfg_ff.settle_ticks);
         REG_STABLE_PRESS:   prdata = PDATA_W'(cfg_ff.stable_press_ticks);
         REG_LONG_PRESS:     prdata = PDATA_W'(cfg_ff.long_press_ticks);
         REG_RELEASE_STABLE: prdata = PDATA_W'(cfg_ff.release_stable_ticks);
         REG_DOUBLE_GAP:     prdata = PDATA_W'(cfg_ff.double_gap_ticks);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ticks         <= SETTLE_RST;
         cfg_ff.stable_press_ticks   <= STABLE_PRESS_RST;
         cfg_ff.long_press_ticks     <= LONG_PRESS_RST;
         cfg_ff.release_stable_ticks <= RELEASE_STABLE_RST;
         cfg_ff.double_gap_ticks     <= DOUBLE_GAP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/bpc_core.sv =====
// ----------------------------------------------------------------------------
// bpc_core
// Press classification state machine: phase, saturating tick counter and
// power flag, advanced once per tick item.
// ----------------------------------------------------------------------------
module bpc_core #(
   parameter int COUNT_WIDTH = bpc_pkg::COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  button_pressed,
   input  bpc_pkg::cfg_type      cfg,
   output bpc_pkg::result_type   result
);
   import bpc_pkg::*;

   localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] PAUSE   = COUNT_WIDTH'(PAUSE_TICKS);

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in, cnt_inc;
   logic                   power_ff, power_in;
   event_type              event_code;
   logic [CMP_W-1:0]       inc_x;
   logic [CMP_W-1:0]       settle_x, stable_x, long_x, release_x, gap_x;

   assign cnt_inc   = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + CNT_ONE;
   assign inc_x     = CMP_W'(cnt_inc);
   assign settle_x  = CMP_W'(cfg.settle_ticks);
   assign stable_x  = CMP_W'(cfg.stable_press_ticks);
   assign long_x    = CMP_W'(cfg.long_press_ticks);
   assign release_x = CMP_W'(cfg.release_stable_ticks);
   assign gap_x     = CMP_W'(cfg.double_gap_ticks);

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      power_in   = power_ff;
      event_code = EV_NONE;
      case (phase_ff)
         PH_IDLE: begin
            if (button_pressed) begin
               phase_in = PH_SETTLE;
               cnt_in   = '0;
            end
         end
         PH_SETTLE: begin
            if (inc_x >= settle_x) begin
               phase_in = PH_DEBOUNCE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_DEBOUNCE: begin
            if (!button_pressed) begin
               cnt_in = '0;
            end else if (inc_x > stable_x) begin
               phase_in = PH_HOLD;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_HOLD: begin
            if (!button_pressed) begin
               phase_in = PH_RELEASE;
               cnt_in   = '0;
            end else if (inc_x > long_x) begin
               power_in   = !power_ff;
               event_code = power_ff ? EV_POWER_DOWN : EV_POWER_UP;
               phase_in   = PH_FINAL;
               cnt_in     = '0;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_RELEASE: begin
            if (button_pressed) begin
               cnt_in = '0;
            end else if (inc_x > release_x) begin
               phase_in = PH_GAP;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_GAP: begin
            if (button_pressed) begin
               phase_in = PH_SECOND;
               cnt_in   = '0;
            end else if (inc_x > gap_x) begin
               event_code = EV_SINGLE;
               phase_in   = PH_FINAL;
               cnt_in     = '0;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_SECOND: begin
            // report on the first released tick; it counts towards the pause
            if (!button_pressed) begin
               event_code = EV_DOUBLE;
               phase_in   = PH_FINAL;
               cnt_in     = CNT_ONE;
            end
         end
         PH_FINAL: begin
            // hold until the button is first seen released
            if (!(cnt_ff == '0 && button_pressed)) begin
               if (cnt_inc >= PAUSE) begin
                  phase_in = PH_IDLE;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   assign result.event_code = event_code;
   assign result.supply_on  = power_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         power_ff <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         power_ff <= power_in;
      end
   end

endmodule

// ===== sv/button_press_classifier.sv =====
// ----------------------------------------------------------------------------
// button_press_classifier
// Single, double and long press detector with power toggle for one button.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one item per 10 ms tick: the sampled button level.
//   rsp_ch returns exactly one item per tick item: an event code (none,
//   power up, single press, double press, power down) and the levels of the
//   main and controller supply enables after that tick.
//   The APB port (psel ... pready) sets the five timing thresholds; write
//   them only while no tick item is in flight. pready is tied high.
// Path: an accepted item is loaded into the input register, is classified
//   into the result register once that register is free or being drained,
//   and is offered on rsp_ch from then on.
// Throughput: one item per cycle while rsp_ch.ready is high; the classifier
//   state updates in a single pass between the input and result registers.
// Reset: phase idle, tick counter zero, power off, no item held; thresholds
//   return to their default values.
// Stall: while rsp_ch.ready is low the result holds; one more item waits in
//   the input register, then req_ch.ready drops.
// ----------------------------------------------------------------------------
module button_press_classifier #(
   parameter int COUNT_WIDTH = bpc_pkg::COUNT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   bpc_req_if.sink                        req_ch,
   bpc_rsp_if.source                      rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bpc_pkg::PADDR_W-1:0]    paddr,
   input  logic [bpc_pkg::PDATA_W-1:0]    pwdata,
   output logic [bpc_pkg::PDATA_W-1:0]    prdata,
   output logic                           pready
);
   import bpc_pkg::*;

   cfg_type    cfg;
   result_type result;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic       in_button_ff;
   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result_ff;
   logic       advance;

   bpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bpc_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .button_pressed (in_button_ff),
      .cfg            (cfg),
      .result         (result)
   );

   // advance the held tick when the result register is free or being drained
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: load the input register on acceptance and the result register on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_button_ff <= req_ch.button_pressed;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.event_code        = result_ff.event_code;
   assign rsp_ch.main_power_enable = result_ff.supply_on;
   assign rsp_ch.mcu_power_enable  = result_ff.supply_on;

`ifndef SYNTH
   // an accepted tick is always held in the input register next cycle
   a_take_held: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> in_valid_ff)
      else $error("accepted item not held in input register");

   // a power-up report leaves the supplies enabled
   a_up_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.event_code == EV_POWER_UP) |-> result_ff.supply_on)
      else $error("power-up reported with supplies off");

   // a power-down report leaves the supplies disabled
   a_down_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.event_code == EV_POWER_DOWN) |-> !result_ff.supply_on)
      else $error("power-down reported with supplies on");

   // a stalled result must not be overwritten by a new classification
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !advance)
      else $error("result register overwritten while stalled");
`endif

endmodule
